@@ rtl/thbl_pkg.sv @@
package thbl_pkg;

	// Transfer kinds; a start request carries one of the active kinds.
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_SEND = 2'd1,
		MODE_RECV = 2'd2,
		MODE_BOOT = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 1'd1;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset value of the acknowledge timeout.
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

	// Status codes; phase aborts are the phase number plus one.
	localparam logic [2:0] STAT_OK = 3'd0;

	// Idle levels of the pins.
	localparam logic [2:0] DATA_IDLE = 3'b111;
	localparam logic       CLK_IDLE  = 1'b1;

	// Input and output beat payload widths.
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 24;

	// One result beat.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [2:0] status;
		logic       done_res;
		logic       busy_res;
		logic       clk_out;
		logic [2:0] data_out;
	} res_t;

endpackage

@@ rtl/three_bit_handshake_link.sv @@
// Channel   Direction  Beat carries
// s_axis    in         tuser: req_type; tdata: tx_byte, ack_in, data_in
// m_axis    out        tdata: data_out, clk_out, busy_res, done_res, status, rx_byte
// cfg       in         cfg_index selects ack_timeout (0) or sample_delay (1)
//
// One input beat is one pin sampling tick and yields one result beat.
// A beat is taken every cycle while s_tready is high; its result is registered.
// A two-entry output buffer keeps s_tready high on a stall until its skid is full.
// Reset puts the link idle: data lines all ones, clock high, ack timeout 1000.
module three_bit_handshake_link (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] tx_byte, [8] ack_in, [11:9] data_in
	input  logic [thbl_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] req_type
	input  logic [thbl_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] data_out, [3] clk_out, [4] busy_res, [5] done_res,
	// [8:6] status, [16:9] rx_byte
	output logic [thbl_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [thbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [thbl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import thbl_pkg::*;

	res_t  step_res;
	res_t  out_res;
	logic  step;
	logic  skid_full;
	mode_t req_type;

	assign cfg_ready = 1'b1;
	assign step      = s_tvalid && s_tready;
	assign req_type  = mode_t'(s_tuser);

	thbl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.step      (step),
		.req_type  (req_type),
		.tx_byte   (s_tdata[7:0]),
		.ack_in    (s_tdata[8]),
		.data_in   (s_tdata[11:9]),
		.res       (step_res)
	);

	thbl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (step_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.skid_full (skid_full)
	);

	assign m_tdata = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_res};

	// A waiting skid entry always sits behind a valid output beat.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> m_tvalid)
		else $error("skid entry valid with empty output register");

	// An abort status only appears on the beat that ends a transfer.
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_res.status != STAT_OK) |-> out_res.done_res)
		else $error("abort status without done");

	// A finished transfer leaves the link idle at its idle levels.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_res.done_res) |->
		(!out_res.busy_res && out_res.clk_out == CLK_IDLE && out_res.data_out == DATA_IDLE))
		else $error("done beat without idle levels");

endmodule

@@ rtl/thbl_core.sv @@
module thbl_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [thbl_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [thbl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               step,
	input  thbl_pkg::mode_t                    req_type,
	input  logic [7:0]                         tx_byte,
	input  logic                               ack_in,
	input  logic [2:0]                         data_in,
	output thbl_pkg::res_t                     res
);
	import thbl_pkg::*;

	logic [15:0] ack_timeout_q;
	logic [7:0]  sample_delay_q;

	mode_t       mode_q, mode_d;
	logic [1:0]  phase_q, phase_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  asm_q, asm_d;
	logic [15:0] wait_q, wait_d;
	logic [7:0]  dly_q, dly_d;
	logic        delaying_q, delaying_d;

	logic        done;
	logic [2:0]  stat;
	logic        adv;
	logic        smp;
	logic [7:0]  dly_inc;
	logic [2:0]  data_drv;

	// Merge the sampled data lines into the byte at the bits of this phase.
	function automatic logic [7:0] merge_bits(input logic [7:0] b, input logic [1:0] ph,
		input logic [2:0] d);
		logic [7:0] r;
		r = b;
		case (ph)
			2'd0: r = b | {d, 5'd0};
			2'd1: r = b | {3'd0, d, 2'd0};
			2'd2: r = b | {6'd0, d[1:0]};
			default: r = b;
		endcase
		return r;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q  <= ACK_TIMEOUT_RST;
			sample_delay_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_wdata;
				REG_SAMPLE_DELAY: sample_delay_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Decide what this tick does: start, delay count, timeout, ack or wait.
	always_comb begin
		adv     = 1'b0;
		smp     = 1'b0;
		stat    = STAT_OK;
		dly_inc = dly_q + 8'd1;
		mode_d     = mode_q;
		phase_d    = phase_q;
		shift_d    = shift_q;
		asm_d      = asm_q;
		wait_d     = wait_q;
		dly_d      = dly_q;
		delaying_d = delaying_q;
		done       = 1'b0;
		if (mode_q == MODE_IDLE) begin
			if (req_type != MODE_IDLE) begin
				mode_d     = req_type;
				phase_d    = 2'd0;
				shift_d    = tx_byte;
				wait_d     = '0;
				dly_d      = '0;
				delaying_d = 1'b0;
				if (req_type == MODE_RECV) begin
					asm_d = '0;
				end
			end
		end else if (delaying_q) begin
			dly_d = dly_inc;
			if (dly_inc >= sample_delay_q) begin
				smp = 1'b1;
				adv = 1'b1;
			end
		end else if (wait_q >= ack_timeout_q) begin
			stat    = {1'b0, phase_q} + 3'd1;
			done    = 1'b1;
			mode_d  = MODE_IDLE;
			phase_d = 2'd0;
			wait_d  = '0;
			dly_d   = '0;
		end else if (ack_in == phase_q[0]) begin
			if (mode_q == MODE_RECV && phase_q != 2'd3) begin
				if (sample_delay_q == 8'd0) begin
					smp = 1'b1;
					adv = 1'b1;
				end else begin
					delaying_d = 1'b1;
					dly_d      = '0;
				end
			end else begin
				adv = 1'b1;
			end
		end else begin
			wait_d = wait_q + 16'd1;
		end

		if (smp) begin
			asm_d = merge_bits(asm_q, phase_q, data_in);
		end

		// Close the phase; the last one ends the transfer.
		if (adv) begin
			delaying_d = 1'b0;
			dly_d      = '0;
			wait_d     = '0;
			if (phase_q == 2'd3) begin
				mode_d  = MODE_IDLE;
				phase_d = 2'd0;
				done    = 1'b1;
			end else begin
				phase_d = phase_q + 2'd1;
			end
		end
	end

	// Pin levels after this tick.
	always_comb begin
		case (mode_d)
			MODE_SEND: begin
				case (phase_d)
					2'd0: data_drv = shift_d[7:5];
					2'd1: data_drv = shift_d[4:2];
					2'd2: data_drv = {1'b0, shift_d[1:0]};
					default: data_drv = DATA_IDLE;
				endcase
			end
			MODE_BOOT: begin
				case (phase_d)
					2'd0: data_drv = {1'b0, shift_d[7:6]};
					2'd1: data_drv = {1'b0, shift_d[5:4]};
					2'd2: data_drv = {1'b0, shift_d[3:2]};
					default: data_drv = {1'b0, shift_d[1:0]};
				endcase
			end
			default: data_drv = DATA_IDLE;
		endcase
	end

	always_comb begin
		res.data_out = data_drv;
		res.clk_out  = (mode_d == MODE_IDLE) ? CLK_IDLE : phase_d[0];
		res.busy_res = (mode_d != MODE_IDLE);
		res.done_res = done;
		res.status   = stat;
		res.rx_byte  = asm_d;
	end

	// Transfer state advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			phase_q    <= '0;
			shift_q    <= '0;
			asm_q      <= '0;
			wait_q     <= '0;
			dly_q      <= '0;
			delaying_q <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			shift_q    <= shift_d;
			asm_q      <= asm_d;
			wait_q     <= wait_d;
			dly_q      <= dly_d;
			delaying_q <= delaying_d;
		end
	end

endmodule

@@ rtl/thbl_obuf.sv @@
module thbl_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  thbl_pkg::res_t in_res,
	output logic           out_valid,
	input  logic           out_ready,
	output thbl_pkg::res_t out_res,
	output logic           skid_full
);
	import thbl_pkg::*;

	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic push;
	logic load_out;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign load_out  = (out_valid_q && out_ready) || !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign skid_full = skid_valid_q;

	// Occupancy of the output register and the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves; the skid entry drains first to keep order.
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= in_res;
			end
		end else if (push) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ verif/three_bit_handshake_link_test.sv @@
module three_bit_handshake_link_test;
	import thbl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	// One sampling tick of the pins as offered on the input stream.
	typedef struct {
		logic [1:0] req;
		logic [7:0] tx;
		logic       ack;
		logic [2:0] din;
	} pin_tick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [7:0] tx_byte, [8] ack_in, [11:9] data_in
	logic [IN_DATA_W-1:0]  s_tdata;
	// [1:0] req_type
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [2:0] data_out, [3] clk_out, [4] busy_res, [5] done_res, [8:6] status, [16:9] rx_byte
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pin_tick_t tick_q[$];
	res_t      pin_levels_q[$];
	int        send_idle_pct;
	int        recv_stall_pct;
	int        n_ticks_queued;
	int        n_ticks_taken;
	int        err_cnt;
	int        cycle_cnt;
	bit        beat_taken;
	bit        hold_req;

	// Link state and register copies of the predictor.
	mode_t       lk_mode;
	logic [1:0]  lk_phase;
	logic [7:0]  lk_shift;
	logic [7:0]  lk_rx;
	logic [15:0] lk_wait;
	logic [7:0]  lk_dly;
	logic        lk_dly_on;
	logic [15:0] lk_tmo;
	logic [7:0]  lk_sdly;

	three_bit_handshake_link u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receive bits land in the byte according to the current phase.
	function automatic void take_bits(input logic [2:0] din);
		case (lk_phase)
			2'd0: lk_rx = lk_rx | {din, 5'b0};
			2'd1: lk_rx = lk_rx | {3'b0, din, 2'b0};
			2'd2: lk_rx = lk_rx | {6'b0, din[1:0]};
			default: ;
		endcase
	endfunction

	// Closes the current phase; returns 1 when the transfer is complete.
	function automatic bit next_phase();
		lk_dly_on = 1'b0;
		lk_dly = '0;
		lk_wait = '0;
		if (lk_phase == 2'd3) begin
			lk_mode = MODE_IDLE;
			lk_phase = 2'd0;
			return 1'b1;
		end
		lk_phase = lk_phase + 2'd1;
		return 1'b0;
	endfunction

	// Advances the link by one tick and returns the pin levels after it.
	function automatic res_t next_pin_levels(input logic [1:0] req, input logic [7:0] txb,
			input logic ack, input logic [2:0] din);
		res_t       r;
		bit         fin;
		logic [2:0] stat;
		fin = 1'b0;
		stat = STAT_OK;
		if (lk_mode == MODE_IDLE) begin
			if (req != MODE_IDLE) begin
				lk_mode = mode_t'(req);
				lk_phase = 2'd0;
				lk_shift = txb;
				if (req == MODE_RECV)
					lk_rx = '0;
				lk_wait = '0;
				lk_dly = '0;
				lk_dly_on = 1'b0;
			end
		end else if (lk_dly_on) begin
			lk_dly = lk_dly + 8'd1;
			if (lk_dly >= lk_sdly) begin
				take_bits(din);
				fin = next_phase();
			end
		end else if (lk_wait >= lk_tmo) begin
			// No acknowledge in time: abort with the phase number plus one.
			stat = {1'b0, lk_phase} + 3'd1;
			fin = 1'b1;
			lk_mode = MODE_IDLE;
			lk_phase = 2'd0;
			lk_wait = '0;
			lk_dly = '0;
		end else if (ack == lk_phase[0]) begin
			if (lk_mode == MODE_RECV && lk_phase != 2'd3) begin
				if (lk_sdly == 8'd0) begin
					take_bits(din);
					fin = next_phase();
				end else begin
					lk_dly_on = 1'b1;
					lk_dly = '0;
				end
			end else begin
				fin = next_phase();
			end
		end else begin
			lk_wait = lk_wait + 16'd1;
		end

		// Levels driven after the update.
		case (lk_mode)
			MODE_SEND: begin
				case (lk_phase)
					2'd0: r.data_out = lk_shift[7:5];
					2'd1: r.data_out = lk_shift[4:2];
					2'd2: r.data_out = {1'b0, lk_shift[1:0]};
					default: r.data_out = DATA_IDLE;
				endcase
			end
			MODE_BOOT: begin
				case (lk_phase)
					2'd0: r.data_out = {1'b0, lk_shift[7:6]};
					2'd1: r.data_out = {1'b0, lk_shift[5:4]};
					2'd2: r.data_out = {1'b0, lk_shift[3:2]};
					default: r.data_out = {1'b0, lk_shift[1:0]};
				endcase
			end
			default: r.data_out = DATA_IDLE;
		endcase
		r.clk_out = (lk_mode == MODE_IDLE) ? CLK_IDLE : lk_phase[0];
		r.busy_res = (lk_mode != MODE_IDLE);
		r.done_res = fin;
		r.status = stat;
		r.rx_byte = lk_rx;
		return r;
	endfunction

	function automatic logic [1:0] busy_req();
		// Mostly plain ticks, sometimes a start that the busy link must ignore.
		if ($urandom_range(3, 0) == 0)
			return 2'($urandom_range(3, 1));
		return MODE_IDLE;
	endfunction

	task automatic push_tick(input logic [1:0] req, input logic [7:0] tx, input logic ack,
			input logic [2:0] din);
		pin_tick_t t;
		t.req = req;
		t.tx = tx;
		t.ack = ack;
		t.din = din;
		tick_q.push_back(t);
		n_ticks_queued++;
	endtask

	// Queues one well-formed transfer for the current register values.
	// abort_ph >= 0 lets that phase run out of time; rx_fill >= 0 fixes data_in.
	task automatic add_transfer(input logic [1:0] kind, input logic [7:0] payload,
			input int abort_ph, input int rx_fill);
		int         p;
		int         k;
		int         n_wrong;
		logic       lvl;
		logic [2:0] d;
		push_tick(kind, payload, 1'($urandom), 3'($urandom));
		if (lk_tmo == 16'd0) begin
			push_tick(busy_req(), 8'($urandom), 1'($urandom), 3'($urandom));
			return;
		end
		for (p = 0; p < 4; p++) begin
			lvl = p[0];
			if (p == abort_ph) begin
				for (k = 0; k <= lk_tmo; k++)
					push_tick(busy_req(), 8'($urandom), !lvl, 3'($urandom));
				return;
			end
			n_wrong = $urandom_range((lk_tmo > 4) ? 4 : lk_tmo - 1, 0);
			for (k = 0; k < n_wrong; k++)
				push_tick(busy_req(), 8'($urandom), !lvl, 3'($urandom));
			d = (rx_fill < 0) ? 3'($urandom) : 3'(rx_fill);
			if (kind == MODE_RECV && p < 3 && lk_sdly != 8'd0) begin
				push_tick(busy_req(), 8'($urandom), lvl, 3'($urandom));
				for (k = 1; k < lk_sdly; k++)
					push_tick(busy_req(), 8'($urandom), 1'($urandom), 3'($urandom));
				push_tick(busy_req(), 8'($urandom), 1'($urandom), d);
			end else begin
				push_tick(busy_req(), 8'($urandom), lvl, d);
			end
		end
	endtask

	// Mostly complete transfers with random content, some raw noise between them.
	task automatic run_random(input int n_ticks, input int abort_pct);
		int stop_at;
		int k;
		int burst;
		int ab;
		stop_at = n_ticks_queued + n_ticks;
		while (n_ticks_queued < stop_at) begin
			if ($urandom_range(99, 0) < 10) begin
				burst = $urandom_range(4, 1);
				for (k = 0; k < burst; k++)
					push_tick(2'($urandom), 8'($urandom), 1'($urandom), 3'($urandom));
			end else begin
				ab = -1;
				if (lk_tmo <= 16'd64 && $urandom_range(99, 0) < abort_pct)
					ab = $urandom_range(3, 0);
				add_transfer(2'($urandom_range(3, 1)), 8'($urandom), ab, -1);
				burst = $urandom_range(2, 0);
				for (k = 0; k < burst; k++)
					push_tick(MODE_IDLE, 8'($urandom), 1'($urandom), 3'($urandom));
			end
		end
	endtask

	// Waits until every queued tick is taken and every result has come back.
	task automatic wait_drain();
		while (n_ticks_taken != n_ticks_queued || pin_levels_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ACK_TIMEOUT: lk_tmo = val;
			REG_SAMPLE_DELAY: lk_sdly = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cmp_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			err_cnt++;
		end
	endtask

	// Input driver: offers the next tick once the current beat is taken.
	always @(negedge clk) begin
		pin_tick_t t;
		if (arst_n && (!s_tvalid || beat_taken)) begin
			beat_taken = 1'b0;
			if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				t = tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= t.req;
				s_tdata <= {4'b0, t.din, t.ack, t.tx};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output ready: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		int hold_left;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Monitor: checks result beats first, then predicts for the accepted tick.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				if (pin_levels_q.size() == 0) begin
					$display("%0t: result beat with none expected, actual %0h", $time, got);
					err_cnt++;
				end else begin
					want = pin_levels_q.pop_front();
					cmp_field("data_out", want.data_out, got.data_out);
					cmp_field("clk_out", want.clk_out, got.clk_out);
					cmp_field("busy_res", want.busy_res, got.busy_res);
					cmp_field("done_res", want.done_res, got.done_res);
					cmp_field("status", want.status, got.status);
					cmp_field("rx_byte", want.rx_byte, got.rx_byte);
				end
			end
			if (s_tvalid && s_tready) begin
				pin_levels_q.push_back(next_pin_levels(s_tuser, s_tdata[7:0], s_tdata[8],
					s_tdata[11:9]));
				n_ticks_taken++;
				beat_taken = 1'b1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("three_bit_handshake_link verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		n_ticks_queued = 0;
		n_ticks_taken = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		beat_taken = 1'b0;
		hold_req = 1'b0;
		lk_mode = MODE_IDLE;
		lk_phase = '0;
		lk_shift = '0;
		lk_rx = '0;
		lk_wait = '0;
		lk_dly = '0;
		lk_dly_on = 1'b0;
		lk_tmo = ACK_TIMEOUT_RST;
		lk_sdly = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings, no idling: directed transfers with extreme and alternating bytes.
		add_transfer(MODE_SEND, 8'hFF, -1, -1);
		add_transfer(MODE_SEND, 8'h00, -1, -1);
		add_transfer(MODE_BOOT, 8'hA5, -1, -1);
		add_transfer(MODE_BOOT, 8'h5A, -1, -1);
		add_transfer(MODE_RECV, 8'h00, -1, 7);
		add_transfer(MODE_RECV, 8'hFF, -1, 0);
		push_tick(MODE_IDLE, 8'hFF, 1'b1, 3'd7);
		run_random(80, 0);
		wait_drain();

		// Short timeout with sampling delay; an abort in every phase.
		write_reg(REG_ACK_TIMEOUT, 16'd5);
		write_reg(REG_SAMPLE_DELAY, 16'd3);
		send_idle_pct = 62;
		add_transfer(MODE_SEND, 8'($urandom), 0, -1);
		add_transfer(MODE_RECV, 8'($urandom), 1, -1);
		add_transfer(MODE_BOOT, 8'($urandom), 2, -1);
		add_transfer(MODE_RECV, 8'($urandom), 3, -1);
		run_random(80, 20);
		wait_drain();

		// Zero timeout: every transfer aborts on its first waiting tick.
		write_reg(REG_ACK_TIMEOUT, 16'd0);
		write_reg(REG_SAMPLE_DELAY, 16'd255);
		send_idle_pct = 0;
		recv_stall_pct = 62;
		run_random(40, 0);
		wait_drain();

		// Longest timeout and delay; the output side holds off for a long stretch.
		write_reg(REG_ACK_TIMEOUT, 16'hFFFF);
		send_idle_pct = 35;
		recv_stall_pct = 35;
		add_transfer(MODE_RECV, 8'($urandom), -1, -1);
		add_transfer(MODE_SEND, 8'($urandom), -1, -1);
		hold_req = 1'b1;
		wait_drain();

		write_reg(REG_ACK_TIMEOUT, 16'd3);
		write_reg(REG_SAMPLE_DELAY, 16'd0);
		send_idle_pct = 0;
		recv_stall_pct = 62;
		run_random(80, 25);
		wait_drain();

		write_reg(REG_ACK_TIMEOUT, 16'($urandom_range(40, 2)));
		write_reg(REG_SAMPLE_DELAY, 16'($urandom_range(8, 1)));
		send_idle_pct = 35;
		recv_stall_pct = 35;
		run_random(80, 15);
		wait_drain();

		repeat (10) @(posedge clk);
		if (err_cnt == 0 && pin_levels_q.size() == 0)
			$display("three_bit_handshake_link verification clean");
		else
			$display("three_bit_handshake_link verification failed");
		$finish;
	end

endmodule

@@ three_bit_handshake_link.f @@
rtl/thbl_pkg.sv
rtl/thbl_core.sv
rtl/thbl_obuf.sv
rtl/three_bit_handshake_link.sv
verif/three_bit_handshake_link_test.sv
